@@ sv/rtel_pkg.sv @@
// Package of shared constants for the range-table energy loss unit.
package rtel_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;

    localparam int REG_TABLE_COUNT = 0;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

@@ sv/range_table_energy_loss_unit.sv @@
// Top level of the range-table energy loss unit: table store, search and arithmetic sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | req_type, entry_index, entry_energy,
//          |           |                      | entry_range, nucleons, energy_per_u, thickness
//  out     | output    | out_valid / out_stall| deposit, stopped
//  apb     | input     | psel / penable       | table_count at byte address 0
//
// A load item is written into both table RAMs at the edge that accepts it, so the block is
// ready again in the next cycle. Each interpolation reads the last and first entries and,
// unless x is clamped at an end, walks one entry a cycle, then runs a shift-add multiply
// and a restoring divide. Reset clears the control and datapath registers and sets the
// count register to one; the tables are undefined until loaded. The result is held in an
// output register and no new item is taken until it has been delivered, so a stall on the
// result side holds off the next item.
module range_table_energy_loss_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  entry_index,
    input  logic [31:0] entry_energy,
    input  logic [31:0] entry_range,
    input  logic [7:0]  nucleons,
    input  logic [31:0] energy_per_u,
    input  logic [31:0] thickness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [39:0] deposit,
    output logic        stopped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = rtel_pkg::IDX_W;
    localparam int CW = rtel_pkg::CNT_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL       = 4'd1;   // shift-add multiply, one bit a cycle
    localparam logic [3:0] S_RD_LAST   = 4'd2;   // address the last entry in use
    localparam logic [3:0] S_RD_FIRST  = 4'd3;   // capture the last entry, address entry 0
    localparam logic [3:0] S_CHK_FIRST = 4'd4;   // clamp checks against both ends
    localparam logic [3:0] S_WALK      = 4'd5;   // linear search, one entry a cycle
    localparam logic [3:0] S_DIV       = 4'd6;   // restoring division
    localparam logic [3:0] S_FIN       = 4'd7;   // combine y0 and quotient
    localparam logic [3:0] S_NEXT      = 4'd8;   // act on an interpolation result
    localparam logic [3:0] S_OUT       = 4'd9;

    // What a finished multiply feeds.
    localparam logic [1:0] PH_TOTAL = 2'd0;   // A*E
    localparam logic [1:0] PH_SEG   = 2'd1;   // offset times segment rise
    localparam logic [1:0] PH_REM   = 2'd2;   // A*Eres

    logic [3:0]    state_reg;
    logic [1:0]    phase_reg;
    logic [8:0]    count_reg;
    logic          pass_reg;        // 0: energy to range, 1: range to energy
    logic [CW-1:0] idx_reg;
    logic [7:0]    a_reg;
    logic [31:0]   t_reg;
    logic [31:0]   x_reg;
    logic [31:0]   px_reg;
    logic [31:0]   py_reg;
    logic [31:0]   lx_reg;
    logic [31:0]   ly_reg;
    logic [31:0]   y_reg;
    logic          neg_reg;
    logic [31:0]   dx_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   mcand_reg;
    logic [31:0]   mplier_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   quo_reg;
    logic [4:0]    step_reg;
    logic [39:0]   total_reg;
    logic [39:0]   loss_reg;
    logic          stop_reg;

    logic [CW-1:0] n_eff;
    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [31:0]   e_rd;
    logic [31:0]   r_rd;
    logic [31:0]   xs;
    logic [31:0]   ys;
    logic [63:0]   acc_sum;
    logic [32:0]   shifted;
    logic [33:0]   trial;

    // A count of zero acts as one entry, and a count above the depth as the whole table.
    always_comb
    begin
        if (count_reg == 9'd0)
        begin
            n_eff = CW'(1);
        end
        else if (count_reg > 9'(rtel_pkg::TABLE_DEPTH))
        begin
            n_eff = CW'(rtel_pkg::TABLE_DEPTH);
        end
        else
        begin
            n_eff = CW'(count_reg);
        end
    end

    // Loads write straight from the input item; otherwise the sequencer owns the address.
    assign ram_we   = (state_reg == S_IDLE) && in_valid && (req_type == rtel_pkg::REQ_LOAD);
    assign ram_addr = ram_we ? entry_index[IW-1:0] : idx_reg[IW-1:0];

    rtel_ram #(.WIDTH(32), .DEPTH(rtel_pkg::TABLE_DEPTH)) u_energy (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(entry_energy), .rdata(e_rd));
    rtel_ram #(.WIDTH(32), .DEPTH(rtel_pkg::TABLE_DEPTH)) u_range (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(entry_range), .rdata(r_rd));

    // The second interpolation swaps the roles of the two columns.
    assign xs = pass_reg ? r_rd : e_rd;
    assign ys = pass_reg ? e_rd : r_rd;

    // The multiplier's adder, shared by all its phases, and the trial subtraction of the divider.
    assign acc_sum = acc_reg + mcand_reg;
    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = {1'b0, shifted} - {2'b00, dx_reg};

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign deposit   = loss_reg;
    assign stopped   = stop_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr == 2'(4 * rtel_pkg::REG_TABLE_COUNT)) ? {23'd0, count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 9'd1;
        end
        else if (psel && penable && pwrite
                 && paddr == 2'(4 * rtel_pkg::REG_TABLE_COUNT))
        begin
            count_reg <= pwdata[8:0];
        end
    end

    // Sequencer and datapath. A query runs A*E, interpolates the range at E, and unless the
    // particle stops, interpolates the residual energy and runs A*Eres.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_TOTAL;
            pass_reg   <= 1'b0;
            idx_reg    <= '0;
            a_reg      <= '0;
            t_reg      <= '0;
            x_reg      <= '0;
            px_reg     <= '0;
            py_reg     <= '0;
            lx_reg     <= '0;
            ly_reg     <= '0;
            y_reg      <= '0;
            neg_reg    <= 1'b0;
            dx_reg     <= '0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            step_reg   <= '0;
            total_reg  <= '0;
            loss_reg   <= '0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && req_type == rtel_pkg::REQ_QUERY)
                    begin
                        a_reg      <= nucleons;
                        t_reg      <= thickness;
                        x_reg      <= energy_per_u;
                        pass_reg   <= 1'b0;
                        acc_reg    <= '0;
                        mcand_reg  <= {32'd0, energy_per_u};
                        mplier_reg <= {24'd0, nucleons};
                        phase_reg  <= PH_TOTAL;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // The multiply ends once no multiplier bits are left.
                    if (mplier_reg == 32'd0)
                    begin
                        case (phase_reg)
                            PH_TOTAL:
                            begin
                                total_reg <= acc_reg[39:0];
                                idx_reg   <= n_eff - CW'(1);
                                state_reg <= S_RD_LAST;
                            end
                            PH_SEG:
                            begin
                                // The high half is below the divisor, so 32 steps suffice.
                                rem_reg   <= acc_reg[63:32];
                                quo_reg   <= acc_reg[31:0];
                                step_reg  <= '0;
                                state_reg <= S_DIV;
                            end
                            default:
                            begin
                                loss_reg  <= (acc_reg[39:0] >= total_reg) ? 40'd0
                                                                          : total_reg - acc_reg[39:0];
                                stop_reg  <= 1'b0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_sum;
                        end
                        mcand_reg  <= {mcand_reg[62:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[31:1]};
                    end
                end
                S_RD_LAST:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_RD_FIRST;
                end
                S_RD_FIRST:
                begin
                    lx_reg    <= xs;
                    ly_reg    <= ys;
                    idx_reg   <= CW'(1);
                    state_reg <= S_CHK_FIRST;
                end
                S_CHK_FIRST:
                begin
                    // Entry 0 is on the read port; entry 1 is being addressed.
                    if (x_reg <= xs)
                    begin
                        y_reg     <= ys;
                        state_reg <= S_NEXT;
                    end
                    else if (x_reg >= lx_reg)
                    begin
                        y_reg     <= ly_reg;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        px_reg    <= xs;
                        py_reg    <= ys;
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // The read port holds entry idx-1. Because x lies below the last entry,
                    // the walk always stops by then, with x above the previous entry.
                    if (x_reg <= xs)
                    begin
                        dx_reg     <= xs - px_reg;
                        neg_reg    <= ys < py_reg;
                        y_reg      <= py_reg;
                        acc_reg    <= '0;
                        mcand_reg  <= {32'd0, x_reg - px_reg};
                        mplier_reg <= (ys < py_reg) ? py_reg - ys : ys - py_reg;
                        phase_reg  <= PH_SEG;
                        state_reg  <= S_MUL;
                    end
                    else
                    begin
                        px_reg  <= xs;
                        py_reg  <= ys;
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_DIV:
                begin
                    if (!trial[33])
                    begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd31)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    y_reg     <= neg_reg ? y_reg - quo_reg : y_reg + quo_reg;
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (!pass_reg)
                    begin
                        // A range no greater than the thickness means the particle stops.
                        if (y_reg <= t_reg)
                        begin
                            loss_reg  <= total_reg;
                            stop_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            x_reg     <= y_reg - t_reg;
                            pass_reg  <= 1'b1;
                            idx_reg   <= n_eff - CW'(1);
                            state_reg <= S_RD_LAST;
                        end
                    end
                    else
                    begin
                        acc_reg    <= '0;
                        mcand_reg  <= {32'd0, y_reg};
                        mplier_reg <= {24'd0, a_reg};
                        phase_reg  <= PH_REM;
                        state_reg  <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/rtel_ram.sv @@
// Generic single-port RAM with registered read data.
module rtel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ dv/range_table_energy_loss_checker.sv @@
// Checker for the range-table energy loss unit: predicts each query result and compares it.
module range_table_energy_loss_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  entry_index,
    input  logic [31:0] entry_energy,
    input  logic [31:0] entry_range,
    input  logic [7:0]  nucleons,
    input  logic [31:0] energy_per_u,
    input  logic [31:0] thickness,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [39:0] deposit,
    input  logic        stopped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_losses
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [39:0] loss;
        logic        stop;
    } loss_result_t;

    logic [31:0]  energy_store [rtel_pkg::TABLE_DEPTH];
    logic [31:0]  range_store  [rtel_pkg::TABLE_DEPTH];
    logic [8:0]   entries_in_use;
    loss_result_t expected_losses [$];

    assign pending_losses = expected_losses.size();

    // Piecewise-linear lookup of ys at x over the first n entries of xs, clamped at both ends.
    function automatic logic [31:0] lookup(input logic [31:0] xs [rtel_pkg::TABLE_DEPTH],
                                           input logic [31:0] ys [rtel_pkg::TABLE_DEPTH],
                                           input int n, input logic [31:0] x);
        logic [63:0] dx;
        logic [63:0] off;
        if (x <= xs[0])
            return ys[0];
        if (x >= xs[n-1])
            return ys[n-1];
        for (int i = 1; i < n; i++)
        begin
            if (x <= xs[i])
            begin
                dx  = 64'(xs[i]) - 64'(xs[i-1]);
                off = 64'(x) - 64'(xs[i-1]);
                if (dx == 0)
                    return ys[i-1];
                if (ys[i] >= ys[i-1])
                    return ys[i-1] + 32'((off * 64'(ys[i] - ys[i-1])) / dx);
                return ys[i-1] - 32'((off * 64'(ys[i-1] - ys[i])) / dx);
            end
        end
        return ys[n-1];
    endfunction

    function automatic loss_result_t predict_loss(input logic [7:0] a, input logic [31:0] e,
                                                  input logic [31:0] t);
        int           n;
        logic [31:0]  r;
        logic [31:0]  eres;
        logic [63:0]  total;
        logic [63:0]  rem;
        loss_result_t res;
        n = (entries_in_use == 0) ? 1
            : (entries_in_use > rtel_pkg::TABLE_DEPTH) ? rtel_pkg::TABLE_DEPTH
            : int'(entries_in_use);
        total = 64'(a) * 64'(e);
        r = lookup(energy_store, range_store, n, e);
        if (r <= t)
        begin
            res.loss = total[39:0];
            res.stop = 1'b1;
        end
        else
        begin
            eres = lookup(range_store, energy_store, n, r - t);
            rem  = 64'(a) * 64'(eres);
            res.loss = (rem >= total) ? 40'd0 : 40'(total - rem);
            res.stop = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        loss_result_t got;
        loss_result_t want;
        if (!rst_n)
        begin
            entries_in_use = 9'd1;
            fail_count = 0;
            expected_losses.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr == 2'(rtel_pkg::REG_TABLE_COUNT * 4))
                entries_in_use = pwdata[8:0];
            if (in_valid && !in_stall)
            begin
                if (req_type == rtel_pkg::REQ_LOAD)
                begin
                    energy_store[entry_index] = entry_energy;
                    range_store[entry_index]  = entry_range;
                end
                else
                    expected_losses = {expected_losses,
                                       predict_loss(nucleons, energy_per_u, thickness)};
            end
            if (out_valid && !out_stall)
            begin
                got.loss = deposit;
                got.stop = stopped;
                if (expected_losses.size() == 0)
                begin
                    $display("%0t: unexpected result deposit=%h stopped=%b", $time,
                             deposit, stopped);
                    fail_count++;
                end
                else
                begin
                    want = expected_losses.pop_front();
                    if (got.loss !== want.loss)
                    begin
                        $display("%0t: deposit expected %h actual %h", $time,
                                 want.loss, got.loss);
                        fail_count++;
                    end
                    if (got.stop !== want.stop)
                    begin
                        $display("%0t: stopped expected %b actual %b", $time,
                                 want.stop, got.stop);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

@@ dv/range_table_energy_loss_unit_tb.sv @@
// Testbench top for the range-table energy loss unit: stimulus, register set-up and verdict.
module range_table_energy_loss_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The whole run, with its longest gaps and stalls, stays far below this.
    localparam int CYCLE_LIMIT = 5_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  entry_index;
    logic [31:0] entry_energy;
    logic [31:0] entry_range;
    logic [7:0]  nucleons;
    logic [31:0] energy_per_u;
    logic [31:0] thickness;
    logic        out_valid;
    logic        out_stall;
    logic [39:0] deposit;
    logic        stopped;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_losses;
    int          cycle_count;
    bit          stall_free;

    // The highest table index loaded in this phase. The bench records it but does not use
    // it to keep queries away from table entries that have never been written.
    int          loaded_upto;
    logic [31:0] axis_energy [rtel_pkg::TABLE_DEPTH];
    logic [31:0] axis_range  [rtel_pkg::TABLE_DEPTH];

    range_table_energy_loss_unit DUT (.*);

    range_table_energy_loss_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A free-running count bounds the run however the block behaves.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stall on the result side: mostly short, now and then long, with stall-free stretches.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_free)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
                out_stall <= 1'b1;
            else
                out_stall <= 1'b0;
            if (out_stall && $urandom_range(0, 30) == 0)
                repeat ($urandom_range(20, 200)) @(posedge clk);
        end
    end

    // Random pause between items on the sending side. With no pause, valid stays high
    // and the next item follows at once.
    task automatic sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (stall_free || r < 60)
            return;
        in_valid <= 1'b0;
        if (r < 95)
            repeat ($urandom_range(1, 4)) @(posedge clk);
        else
            repeat ($urandom_range(20, 300)) @(posedge clk);
    endtask

    // Presents one item and holds it until the block accepts it.
    task automatic send_item(input logic kind, input logic [7:0] idx, input logic [31:0] en,
                             input logic [31:0] rg, input logic [7:0] a,
                             input logic [31:0] e, input logic [31:0] t);
        in_valid     <= 1'b1;
        req_type     <= kind;
        entry_index  <= idx;
        entry_energy <= en;
        entry_range  <= rg;
        nucleons     <= a;
        energy_per_u <= e;
        thickness    <= t;
        do
            @(posedge clk);
        while (in_stall);
        sender_gap();
    endtask

    task automatic load_entry(input int idx, input logic [31:0] en, input logic [31:0] rg);
        send_item(rtel_pkg::REQ_LOAD, 8'(idx), en, rg, 8'($urandom), $urandom, $urandom);
        axis_energy[idx] = en;
        axis_range[idx]  = rg;
        if (idx > loaded_upto)
            loaded_upto = idx;
    endtask

    task automatic query(input logic [7:0] a, input logic [31:0] e, input logic [31:0] t);
        send_item(rtel_pkg::REQ_QUERY, 8'($urandom), $urandom, $urandom, a, e, t);
    endtask

    // Registers change only once the block has gone quiet: every result back and the
    // block ready for a new item, as sampled at the clock.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_losses != 0 || in_stall);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_count(input logic [31:0] value);
        in_valid <= 1'b0;
        psel     <= 1'b1;
        pwrite   <= 1'b1;
        paddr    <= 2'(rtel_pkg::REG_TABLE_COUNT * 4);
        pwdata   <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Fills entries 0..n-1 ascending in both columns, with random step sizes.
    // Zero steps now and then give flat segments; small steps give tight ones.
    task automatic load_ascending(input int n, input logic [31:0] step_max);
        logic [31:0] en;
        logic [31:0] rg;
        en = $urandom_range(0, 32'h0004_0000);
        rg = $urandom_range(0, 32'h0000_1000);
        for (int i = 0; i < n; i++)
        begin
            load_entry(i, en, rg);
            en += ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, step_max);
            rg += ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, step_max);
        end
    endtask

    // Picks an energy around the loaded table, beyond both ends now and then.
    function automatic logic [31:0] pick_energy(input int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'(axis_energy[0] - $urandom_range(0, 5000));
            2: return axis_energy[k];
            default: return axis_energy[k] + $urandom_range(0, 32'h0008_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_thickness(input int n);
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'd0;
            2: return axis_range[$urandom_range(0, n - 1)];
            default: return $urandom_range(0, axis_range[n-1] - axis_range[0] + 32'd2000);
        endcase
    endfunction

    initial
    begin
        int n;
        int used;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = rtel_pkg::REQ_LOAD;
        entry_index  = '0;
        entry_energy = '0;
        entry_range  = '0;
        nucleons     = '0;
        energy_per_u = '0;
        thickness    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        stall_free   = 1'b0;
        loaded_upto  = -1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With the count at its reset value only entry 0 is read.
        load_entry(0, 32'h0001_0000, 32'h0000_0100);
        query(8'd1, 32'h0000_0000, 32'h0000_0000);
        query(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query(8'd0, 32'h0002_0000, 32'h0000_0000);
        wait_idle();

        // A small table with a falling segment, a flat segment and full-scale values.
        load_entry(1, 32'h0002_0000, 32'h0000_0400);
        load_entry(2, 32'h0002_0000, 32'h0000_0800);
        load_entry(3, 32'h0008_0000, 32'h0000_0200);
        load_entry(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(rtel_pkg::REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 32'd0, 32'd0);
        axis_energy[255] = 32'hFFFF_FFFF;
        axis_range[255]  = 32'hFFFF_FFFF;
        write_count(32'd5);
        query(8'd4, 32'h0001_8000, 32'h0000_0010);
        query(8'd12, 32'h0005_0000, 32'h0000_0001);
        query(8'd255, 32'h8000_0000, 32'h0000_0000);
        query(8'd255, 32'hFFFF_FFFF, 32'h0000_0000);
        query(8'd7, 32'h0002_0000, 32'h0000_0100);
        query(8'd0, 32'h0005_0000, 32'h0000_0100);
        wait_idle();
        // A count of zero behaves as one entry.
        write_count(32'd0);
        query(8'd3, 32'h0003_0000, 32'h0000_0080);
        wait_idle();
        // A count written with all bits set is clipped to the table depth.
        load_ascending(256, 32'h0000_4000);
        write_count(32'hFFFF_FFFF);
        query(8'd200, pick_energy(256), 32'h0000_0400);
        query(8'd9, pick_energy(256), 32'd0);
        wait_idle();
        write_count(32'd256);
        query(8'd16, pick_energy(256), pick_thickness(256));
        wait_idle();

        // Random phases: a fresh table, a new count, then a stream of queries with the
        // occasional reload of an entry already loaded. Small tables dominate.
        for (int phase = 0; phase < 10; phase++)
        begin
            wait_idle();
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 256) : $urandom_range(2, 24);
            loaded_upto = -1;
            load_ascending(n, ($urandom_range(0, 1) != 0) ? 32'h0001_0000 : 32'h00FF_FFFF);
            used = ($urandom_range(0, 4) == 0) ? 1 : n;
            write_count(32'(used));
            stall_free = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 40; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_entry($urandom_range(0, n - 1), $urandom, $urandom);
                else
                    query(($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(1, 255)),
                          pick_energy(n), pick_thickness(n));
            end
        end
        stall_free = 1'b0;

        wait_idle();
        repeat (600) @(posedge clk);
        if (fail_count == 0 && pending_losses == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
